FILE: sv/lcl_pkg.sv
// ----------------------------------------------------------------------------
// lcl_pkg
// Shared constants and types of the link cluster labeler.
// ----------------------------------------------------------------------------
package lcl_pkg;

  localparam int MAX_CUST = 64;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;

  localparam logic [1:0] OP_QUERY  = 2'd0;
  localparam logic [1:0] OP_UNLINK = 2'd1;
  localparam logic [1:0] OP_LINK   = 2'd2;

  localparam logic       ST_OK  = 1'b0;
  localparam logic       ST_BAD = 1'b1;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] data;
  } ram_wr_t;

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_U_START = 14'b00000000000010,
    S_U_C     = 14'b00000000000100,
    S_U_SCAN  = 14'b00000000001000,
    S_U_PROP  = 14'b00000000010000,
    S_U_SPLIT = 14'b00000000100000,
    S_U_RELAB = 14'b00000001000000,
    S_U_END   = 14'b00000010000000,
    S_L_SET   = 14'b00000100000000,
    S_L_KL    = 14'b00001000000000,
    S_L_SCAN  = 14'b00010000000000,
    S_RD_OUT  = 14'b00100000000000,
    S_RD_WAIT = 14'b01000000000000,
    S_FIN     = 14'b10000000000000
  } state_t;

endpackage

FILE: sv/lcl_idx_ram.sv
// ----------------------------------------------------------------------------
// lcl_idx_ram
// Index-wide memory with one write port, one registered read port and a
// valid bit per entry; an entry never written reads as its own address.
// ----------------------------------------------------------------------------
module lcl_idx_ram
  import lcl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  ram_wr_t          wr,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [IDX_W-1:0] rd_data
);

  logic [IDX_W-1:0]    mem [MAX_CUST];
  logic [MAX_CUST-1:0] vld_r;
  logic [IDX_W-1:0]    q_r;
  logic                qv_r;
  logic [IDX_W-1:0]    qa_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    q_r  <= mem[rd_addr];
    qa_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      qv_r <= vld_r[rd_addr];
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
    end
  end

  assign rd_data = qv_r ? q_r : qa_r;

endmodule

FILE: sv/link_cluster_labeler.sv
// ----------------------------------------------------------------------------
// link_cluster_labeler
// Keeps connected-component labels of a one-link-per-customer graph, updated
// by link and unlink items, and answers each item with label and count.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    opcode, customer, target
//   out_     output     out_valid / out_ready  table_label, table_count, status
//   config   APB write  psel, penable, pwrite  active_customers at address 0
//
// A query reads the customer's label; a rejected item goes straight to the
// result. Unlink scans the N active customers, repeats reachability passes
// until one changes nothing, and relabels a split part if a label is free;
// link unlinks a present link first, then merges both labels unless equal.
// in_ready is high only while the sequencer is idle; a new result waits for the
// previous one to leave the output register. Reset restores 64 self-linked.
module link_cluster_labeler
  import lcl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_opcode,
  input  logic [IDX_W-1:0] in_customer,
  input  logic [IDX_W-1:0] in_target,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] out_table_label,
  output logic [CNT_W-1:0] out_table_count,
  output logic             out_status,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  state_t              state_r;
  logic [CNT_W-1:0]    n_r;
  logic [CNT_W-1:0]    total_r;
  logic [1:0]          op_r;
  logic [IDX_W-1:0]    cu_r;
  logic [IDX_W-1:0]    tg_r;
  logic [CNT_W-1:0]    i_r;
  logic                s1_v_r;
  logic [IDX_W-1:0]    s1_i_r;
  logic [IDX_W-1:0]    c_r;
  logic [IDX_W-1:0]    r_r;
  logic                rf_r;
  logic                chg_r;
  logic                split_r;
  logic [IDX_W-1:0]    k_r;
  logic [IDX_W-1:0]    l_r;
  logic [IDX_W-1:0]    lo_r;
  logic [IDX_W-1:0]    hi_r;
  logic [MAX_CUST-1:0] present_r;
  logic [MAX_CUST-1:0] member_r;
  logic [MAX_CUST-1:0] mark_r;
  logic [IDX_W-1:0]    res_label_r;
  logic                res_status_r;
  logic                out_valid_r;
  logic [IDX_W-1:0]    out_label_r;
  logic [CNT_W-1:0]    out_count_r;
  logic                out_status_r;

  logic                cfg_wr;
  logic [CNT_W-1:0]    cfg_val;
  logic                in_acc;
  logic                in_bad;
  logic                scan_on;
  logic [IDX_W-1:0]    la_addr;
  logic [IDX_W-1:0]    la_data;
  logic [IDX_W-1:0]    lb_data;
  logic [IDX_W-1:0]    lk_data;
  ram_wr_t             lab_wr;
  ram_wr_t             lnk_wr;
  logic                prop_hit;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata   = (paddr[2] == 1'b0) ? {{(32-CNT_W){1'b0}}, n_r} : 32'd0;

  always_comb begin
    cfg_val = pwdata[CNT_W-1:0];
    if (cfg_val == '0) begin
      cfg_val = CNT_W'(1);
    end else if (cfg_val > CNT_W'(MAX_CUST)) begin
      cfg_val = CNT_W'(MAX_CUST);
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign in_bad   = ({1'b0, in_customer} >= n_r) ||
                    ((in_opcode == OP_LINK) && ({1'b0, in_target} >= n_r));
  assign scan_on  = (i_r < n_r);

  assign out_valid       = out_valid_r;
  assign out_table_label = out_label_r;
  assign out_table_count = out_count_r;
  assign out_status      = out_status_r;

  always_comb begin
    unique case (state_r)
      S_U_SCAN, S_L_SCAN: la_addr = i_r[IDX_W-1:0];
      default:            la_addr = cu_r;
    endcase
  end

  assign prop_hit = s1_v_r && member_r[s1_i_r] && present_r[s1_i_r] &&
                    ({1'b0, lk_data} < n_r) && member_r[lk_data] &&
                    (mark_r[s1_i_r] != mark_r[lk_data]);

  always_comb begin
    lab_wr = '0;
    if ((state_r == S_U_RELAB) && scan_on &&
        member_r[i_r[IDX_W-1:0]] && !mark_r[i_r[IDX_W-1:0]]) begin
      lab_wr.en   = 1'b1;
      lab_wr.addr = i_r[IDX_W-1:0];
      lab_wr.data = total_r[IDX_W-1:0];
    end else if ((state_r == S_L_SCAN) && s1_v_r) begin
      lab_wr.addr = s1_i_r;
      if ((la_data == k_r) || (la_data == l_r)) begin
        lab_wr.en   = 1'b1;
        lab_wr.data = lo_r;
      end else if (la_data > hi_r) begin
        lab_wr.en   = 1'b1;
        lab_wr.data = la_data - IDX_W'(1);
      end
    end
  end

  always_comb begin
    lnk_wr      = '0;
    lnk_wr.en   = (state_r == S_L_SET);
    lnk_wr.addr = cu_r;
    lnk_wr.data = tg_r;
  end

  lcl_idx_ram u_lab_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (cfg_wr),
    .wr      (lab_wr),
    .rd_addr (la_addr),
    .rd_data (la_data)
  );

  lcl_idx_ram u_lab_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (cfg_wr),
    .wr      (lab_wr),
    .rd_addr (tg_r),
    .rd_data (lb_data)
  );

  lcl_idx_ram u_lnk (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (cfg_wr),
    .wr      (lnk_wr),
    .rd_addr (i_r[IDX_W-1:0]),
    .rd_data (lk_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= CNT_W'(MAX_CUST);
      total_r     <= CNT_W'(MAX_CUST);
      present_r   <= '1;
      out_valid_r <= 1'b0;
      s1_v_r      <= 1'b0;
      i_r         <= '0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        n_r       <= cfg_val;
        total_r   <= cfg_val;
        present_r <= '1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            op_r <= in_opcode;
            cu_r <= in_customer;
            tg_r <= in_target;
            if (in_bad) begin
              res_label_r  <= '0;
              res_status_r <= ST_BAD;
              state_r      <= S_FIN;
            end else if (in_opcode == OP_UNLINK) begin
              state_r <= S_U_START;
            end else if (in_opcode == OP_LINK) begin
              state_r <= present_r[in_customer] ? S_U_START : S_L_SET;
            end else begin
              state_r <= S_RD_OUT;
            end
          end
        end
        S_U_START: begin
          present_r[cu_r] <= 1'b0;
          member_r        <= '0;
          mark_r          <= '0;
          state_r         <= S_U_C;
        end
        S_U_C: begin
          c_r     <= la_data;
          rf_r    <= 1'b0;
          i_r     <= '0;
          s1_v_r  <= 1'b0;
          state_r <= S_U_SCAN;
        end
        S_U_SCAN: begin
          s1_v_r <= scan_on;
          s1_i_r <= i_r[IDX_W-1:0];
          if (scan_on) begin
            i_r <= i_r + CNT_W'(1);
          end
          if (s1_v_r && (la_data == c_r)) begin
            member_r[s1_i_r] <= 1'b1;
            if (!rf_r) begin
              r_r  <= s1_i_r;
              rf_r <= 1'b1;
            end
          end
          if (!scan_on && !s1_v_r) begin
            mark_r[r_r] <= 1'b1;
            i_r         <= '0;
            chg_r       <= 1'b0;
            state_r     <= S_U_PROP;
          end
        end
        S_U_PROP: begin
          s1_v_r <= scan_on;
          s1_i_r <= i_r[IDX_W-1:0];
          if (scan_on) begin
            i_r <= i_r + CNT_W'(1);
          end
          if (prop_hit) begin
            mark_r[s1_i_r]  <= 1'b1;
            mark_r[lk_data] <= 1'b1;
            chg_r           <= 1'b1;
          end
          if (!scan_on && !s1_v_r) begin
            i_r   <= '0;
            chg_r <= 1'b0;
            if (!chg_r) begin
              split_r <= 1'b0;
              state_r <= S_U_SPLIT;
            end
          end
        end
        S_U_SPLIT: begin
          if (scan_on) begin
            i_r <= i_r + CNT_W'(1);
            if (member_r[i_r[IDX_W-1:0]] && !mark_r[i_r[IDX_W-1:0]]) begin
              split_r <= 1'b1;
            end
          end else begin
            i_r     <= '0;
            state_r <= (split_r && (total_r < n_r)) ? S_U_RELAB : S_U_END;
          end
        end
        S_U_RELAB: begin
          if (scan_on) begin
            i_r <= i_r + CNT_W'(1);
          end else begin
            total_r <= total_r + CNT_W'(1);
            state_r <= S_U_END;
          end
        end
        S_U_END: begin
          state_r <= (op_r == OP_LINK) ? S_L_SET : S_RD_OUT;
        end
        S_L_SET: begin
          present_r[cu_r] <= 1'b1;
          state_r         <= S_L_KL;
        end
        S_L_KL: begin
          k_r    <= la_data;
          l_r    <= lb_data;
          lo_r   <= (la_data < lb_data) ? la_data : lb_data;
          hi_r   <= (la_data < lb_data) ? lb_data : la_data;
          i_r    <= '0;
          s1_v_r <= 1'b0;
          state_r <= (la_data == lb_data) ? S_RD_OUT : S_L_SCAN;
        end
        S_L_SCAN: begin
          s1_v_r <= scan_on;
          s1_i_r <= i_r[IDX_W-1:0];
          if (scan_on) begin
            i_r <= i_r + CNT_W'(1);
          end
          if (!scan_on && !s1_v_r) begin
            if (total_r > CNT_W'(1)) begin
              total_r <= total_r - CNT_W'(1);
            end
            state_r <= S_RD_OUT;
          end
        end
        S_RD_OUT: begin
          state_r <= S_RD_WAIT;
        end
        S_RD_WAIT: begin
          res_label_r  <= la_data;
          res_status_r <= ST_OK;
          state_r      <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_label_r  <= res_label_r;
            out_count_r  <= total_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the link cluster labeler against a cycle-free table model. Link,
// unlink and query items are offered with random gaps, every answer is
// compared in order with the predicted label, count and status, and the
// customer count is rewritten between phases, its extremes among them.
// ----------------------------------------------------------------------------
module tb;
  import lcl_pkg::*;

  localparam logic [1:0] OP_SPARE    = 2'd3;
  localparam logic [2:0] REG_ACTIVE  = 3'd0;
  localparam int         STALL_LIMIT = 20000;
  localparam int         HOLD_AT     = 250;
  localparam int         HOLD_LEN    = 400;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] cust;
    logic [IDX_W-1:0] tgt;
  } cust_op_t;

  typedef struct packed {
    logic [IDX_W-1:0] table_label;
    logic [CNT_W-1:0] table_count;
    logic             status;
  } answer_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       in_opcode = OP_QUERY;
  logic [IDX_W-1:0] in_customer = '0;
  logic [IDX_W-1:0] in_target = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [IDX_W-1:0] out_table_label;
  logic [CNT_W-1:0] out_table_count;
  logic             out_status;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [2:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  cust_op_t pending_ops[$];
  answer_t  expected_answers[$];
  int       queued_total = 0;
  int       in_count = 0;
  int       errors = 0;
  int       cyc = 0;
  int       hold_left = 0;
  bit       hold_done = 0;
  logic     in_done = 1'b0;
  logic     calm;

  // Table model of the block.
  logic [IDX_W-1:0] link_to[MAX_CUST];
  bit               link_on[MAX_CUST];
  logic [IDX_W-1:0] lab[MAX_CUST];
  bit               reached[MAX_CUST];
  logic [CNT_W-1:0] ntab;
  logic [CNT_W-1:0] nact;

  link_cluster_labeler DUT (.*);

  initial forever #6 clk = ~clk;

  assign calm = (cyc >= 30000) && (cyc < 70000);

  function automatic void tbl_init(logic [CNT_W-1:0] n);
    nact = n;
    for (int i = 0; i < MAX_CUST; i++) begin
      link_to[i] = IDX_W'(i);
      link_on[i] = 1'b1;
      lab[i] = IDX_W'(i);
      reached[i] = 1'b0;
    end
    ntab = n;
  endfunction

  function automatic void tbl_unlink(int s);
    int  c, r, t;
    bit  changed, split;
    c = int'(lab[s]);
    r = s;
    split = 1'b0;
    link_on[s] = 1'b0;
    for (int i = 0; i < nact; i++) begin
      reached[i] = 1'b0;
      if (lab[i] == c && i < r) r = i;
    end
    reached[r] = 1'b1;
    changed = 1'b1;
    while (changed) begin
      changed = 1'b0;
      for (int i = 0; i < nact; i++) begin
        t = int'(link_to[i]);
        if (lab[i] == c && link_on[i] && t < nact && lab[t] == c &&
            reached[i] != reached[t]) begin
          reached[i] = 1'b1;
          reached[t] = 1'b1;
          changed = 1'b1;
        end
      end
    end
    for (int i = 0; i < nact; i++)
      if (lab[i] == c && !reached[i]) split = 1'b1;
    if (split && ntab < nact) begin
      for (int i = 0; i < nact; i++)
        if (lab[i] == c && !reached[i]) lab[i] = ntab[IDX_W-1:0];
      ntab = ntab + CNT_W'(1);
    end
  endfunction

  function automatic void tbl_link(int s, int t);
    int k, l, lo, hi;
    if (link_on[s]) tbl_unlink(s);
    link_to[s] = IDX_W'(t);
    link_on[s] = 1'b1;
    k = int'(lab[s]);
    l = int'(lab[t]);
    if (k != l) begin
      lo = (k < l) ? k : l;
      hi = (k < l) ? l : k;
      for (int i = 0; i < nact; i++) begin
        if (lab[i] == k || lab[i] == l) lab[i] = IDX_W'(lo);
        else if (lab[i] > hi) lab[i] = lab[i] - IDX_W'(1);
      end
      if (ntab > 1) ntab = ntab - CNT_W'(1);
    end
  endfunction

  function automatic answer_t predict_answer(logic [1:0] op, logic [IDX_W-1:0] c,
                                             logic [IDX_W-1:0] t);
    answer_t a;
    if (c >= nact || (op == OP_LINK && t >= nact)) begin
      a.table_label = '0;
      a.table_count = ntab;
      a.status = ST_BAD;
    end else begin
      if (op == OP_UNLINK) tbl_unlink(int'(c));
      else if (op == OP_LINK) tbl_link(int'(c), int'(t));
      a.table_label = lab[c];
      a.table_count = ntab;
      a.status = ST_OK;
    end
    return a;
  endfunction

  function automatic cust_op_t rand_op(int n);
    cust_op_t it;
    int       pick;
    pick = int'($urandom_range(99));
    it.cust = IDX_W'($urandom_range(n - 1));
    it.tgt = IDX_W'($urandom_range(n - 1));
    if (pick < 25) begin
      it.op = OP_LINK;
    end else if (pick < 45) begin
      it.op = OP_LINK;
      it.tgt = IDX_W'((int'(it.cust) + 1) % n);
    end else if (pick < 72) begin
      it.op = OP_UNLINK;
    end else if (pick < 84) begin
      it.op = OP_QUERY;
      it.tgt = IDX_W'($urandom);
    end else if (pick < 88) begin
      it.op = OP_SPARE;
      it.tgt = IDX_W'($urandom);
    end else begin
      it.op = 2'($urandom);
      it.cust = IDX_W'($urandom);
      it.tgt = IDX_W'($urandom);
    end
    return it;
  endfunction

  task automatic queue_op(logic [1:0] op, int c, int t);
    pending_ops.push_back('{op, c[IDX_W-1:0], t[IDX_W-1:0]});
    queued_total++;
  endtask

  task automatic queue_random(int n, int cnt);
    repeat (cnt) begin
      pending_ops.push_back(rand_op(n));
      queued_total++;
    end
  endtask

  task automatic settle();
    while (in_count != queued_total || expected_answers.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_cfg(logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_ACTIVE;
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(logic [31:0] v, int n, int cnt);
    write_cfg(v);
    queue_random(n, cnt);
    settle();
  endtask

  // Item driver.
  always @(negedge clk) begin : drive_items
    cust_op_t nxt;
    if (rst_n && (!in_valid || in_done)) begin
      if (pending_ops.size() != 0 && (calm || $urandom_range(99) >= 30)) begin
        nxt = pending_ops.pop_front();
        in_valid <= 1'b1;
        in_opcode <= nxt.op;
        in_customer <= nxt.cust;
        in_target <= nxt.tgt;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver, with one long hold-off so the block fills and stalls.
  always @(negedge clk) begin
    if (!hold_done && in_count >= HOLD_AT) begin
      hold_left = HOLD_LEN;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 30);
    end
  end

  // Monitor and scoreboard.
  always @(posedge clk) begin : monitor
    answer_t          got, want;
    logic [CNT_W-1:0] nv;
    cyc <= cyc + 1;
    in_done <= in_valid && in_ready;
    if (!rst_n) begin
      tbl_init(CNT_W'(MAX_CUST));
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_ACTIVE) begin
        nv = pwdata[CNT_W-1:0];
        if (nv < CNT_W'(1)) nv = CNT_W'(1);
        if (nv > CNT_W'(MAX_CUST)) nv = CNT_W'(MAX_CUST);
        tbl_init(nv);
      end
      if (in_valid && in_ready) begin
        expected_answers.push_back(predict_answer(in_opcode, in_customer, in_target));
        in_count <= in_count + 1;
      end
      if (out_valid && out_ready) begin
        got = '{out_table_label, out_table_count, out_status};
        if (expected_answers.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: result with none pending label=%0d count=%0d status=%0d",
                     got.table_label, got.table_count, got.status);
        end else begin
          want = expected_answers.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: label %0d/%0d count %0d/%0d status %0d/%0d (exp/act)",
                       want.table_label, got.table_label, want.table_count,
                       got.table_count, want.status, got.status);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Full size after reset: self links, cycles, splits and merges.
    queue_op(OP_QUERY, 0, 0);
    queue_op(OP_QUERY, 63, 63);
    queue_op(OP_LINK, 0, 63);
    queue_op(OP_LINK, 63, 0);
    queue_op(OP_LINK, 5, 5);
    queue_op(OP_UNLINK, 63, 0);
    queue_op(OP_UNLINK, 63, 42);
    queue_op(OP_UNLINK, 0, 21);
    queue_op(OP_LINK, 62, 0);
    queue_op(OP_LINK, 1, 2);
    queue_op(OP_LINK, 2, 3);
    queue_op(OP_LINK, 3, 1);
    queue_op(OP_UNLINK, 2, 63);
    queue_op(OP_QUERY, 3, 42);
    queue_op(OP_SPARE, 63, 21);
    queue_op(OP_LINK, 42, 21);
    queue_op(OP_LINK, 21, 42);
    settle();

    // A zero count is taken as one customer; most indices are out of range.
    write_cfg(32'd0);
    queue_op(OP_QUERY, 0, 0);
    queue_op(OP_QUERY, 1, 0);
    queue_op(OP_LINK, 0, 0);
    queue_op(OP_LINK, 0, 1);
    queue_op(OP_UNLINK, 0, 0);
    queue_op(OP_UNLINK, 0, 0);
    queue_op(OP_LINK, 0, 0);
    queue_op(OP_QUERY, 63, 0);
    queue_op(OP_SPARE, 5, 0);
    queue_op(OP_UNLINK, 32, 0);
    queue_random(1, 60);
    settle();

    run_phase(32'd2, 2, 100);
    run_phase(32'd9, 9, 200);
    run_phase(32'hFFFF_FF97, 23, 200);
    run_phase(32'd127, 64, 180);
    run_phase(32'd64, 64, 100);
    run_phase(32'd5, 5, 120);

    if (errors == 0 && expected_answers.size() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
